// ===== sv/ahce_pkg.sv =====
// Shared types, constants and helper functions for the ASCII hex CRC frame encoder.
package ahce_pkg;

    typedef struct packed {
        logic signed [31:0] count_x;
        logic signed [31:0] count_y;
        logic signed [31:0] count_z;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIGIT,
        S_COMMA,
        S_CRC_LOAD,
        S_CRC_DIGIT,
        S_CR,
        S_LF
    } state_t;

    typedef struct packed {
        logic       init;
        logic       upd;
        logic [7:0] data;
    } crc_ctl_t;

    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT     = 32'hFFFF_FFFF;
    localparam logic [7:0]  MSG_TYPE_RESET = 8'h0F;
    localparam logic [7:0]  ASCII_ZERO     = 8'h30;
    localparam logic [7:0]  ASCII_A        = 8'h41;
    localparam logic [7:0]  ASCII_COMMA    = 8'h2C;
    localparam logic [7:0]  ASCII_CR       = 8'h0D;
    localparam logic [7:0]  ASCII_LF       = 8'h0A;
    // fields in the queue: length, type, sequence, x, y, z
    localparam logic [2:0]  FIELD_LAST     = 3'd5;
    // line is capped at 51 characters; at 50 before CR LF the CR is dropped
    localparam logic [6:0]  CR_DROP_LEN    = 7'd50;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib inside {[4'd0:4'd9]})
            c = ASCII_ZERO + {4'b0000, nib};
        else
            c = ASCII_A + {4'b0000, nib - 4'd10};
        return c;
    endfunction

    // number of hex digits without leading zeros, at least one
    function automatic logic [3:0] hex_digits(input logic [31:0] v);
        logic [3:0] nd;
        nd = 4'd1;
        for (int k = 0; k < 8; k++)
        begin
            if (v[4*k +: 4] != 4'h0)
                nd = 4'(k + 1);
        end
        return nd;
    endfunction

    // moves the first significant digit to the top nibble
    function automatic logic [31:0] hex_align(input logic [31:0] v, input logic [3:0] nd);
        logic [4:0] sh;
        sh = {3'(4'd8 - nd), 2'b00};
        return v << sh;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== sv/ahce_crc.sv =====
// Byte-wide reflected CRC-32 accumulator over the payload characters.
module ahce_crc (
    input  logic              clk,
    input  ahce_pkg::crc_ctl_t ctl,
    output logic [31:0]       crc
);

    logic [31:0] crc_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.init)
            crc_reg <= ahce_pkg::CRC_INIT;
        else if (ctl.upd)
            crc_reg <= ahce_pkg::crc_byte(crc_reg, ctl.data);
    end

    assign crc = crc_reg ^ ahce_pkg::CRC_XOROUT;

endmodule

// ===== sv/ascii_hex_crc_frame_encoder_core.sv =====
// Top level of the ASCII hex CRC frame encoder.
// Each accepted transaction (three 32-bit counts) produces one text line
// "LEN,TYPE,SEQ,X,Y,Z,CRC\r\n" in uppercase hex without leading zeros, one
// character per result transaction, with last set on the line feed. The
// sequence number starts at 0 after reset and steps once per frame. A frame
// of N characters (15 to 51) leaves one character per cycle through the
// output register while result_stall is low; a CRC load state lines up
// the CRC digits. Fields are held in a queue of 32-bit shift registers and
// leave one nibble per cycle while not stalled; the CRC is updated one byte
// per cycle as payload characters go out. item_stall is high from acceptance
// until the line feed is issued. The user must see that message_type is
// written through cfg_we/cfg_data only while the block is idle (unenforced).
module ascii_hex_crc_frame_encoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ahce_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output ahce_pkg::out_item_t result,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data
);

    localparam int QUEUE_DEPTH = 6;

    ahce_pkg::state_t    state_reg, state_next;
    logic [7:0]          msg_type_reg;
    logic [31:0]         seq_reg;
    logic [2:0]          fcnt_reg;
    logic                cr_en_reg;
    logic [5:0]          plen_reg;
    logic [1:0]          lendig_reg;
    logic [31:0]         fld_reg [QUEUE_DEPTH];
    logic [3:0]          nd_reg  [QUEUE_DEPTH];
    logic                out_valid_reg;
    ahce_pkg::out_item_t out_data_reg;

    logic                accept;
    logic                adv;
    logic                emit;
    ahce_pkg::out_item_t emit_data;
    ahce_pkg::crc_ctl_t  crc_ctl;
    logic [31:0]         crc;
    logic [3:0]          nd_type, nd_seq, nd_x, nd_y, nd_z, nd_crc;
    logic [5:0]          plen;
    logic [3:0]          nd_plen;
    logic [6:0]          line_len;

    assign item_stall = (state_reg != ahce_pkg::S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign adv        = !out_valid_reg || !result_stall;

    // digit counts of the fields at acceptance
    assign nd_type = ahce_pkg::hex_digits({24'h000000, msg_type_reg});
    assign nd_seq  = ahce_pkg::hex_digits(seq_reg);
    assign nd_x    = ahce_pkg::hex_digits(item.count_x);
    assign nd_y    = ahce_pkg::hex_digits(item.count_y);
    assign nd_z    = ahce_pkg::hex_digits(item.count_z);
    assign plen    = 6'd5 + 6'(nd_type) + 6'(nd_seq) + 6'(nd_x) + 6'(nd_y) + 6'(nd_z);
    assign nd_plen = ahce_pkg::hex_digits({26'h0, plen});

    assign nd_crc   = ahce_pkg::hex_digits(crc);
    assign line_len = 7'(lendig_reg) + 7'd1 + 7'(plen_reg) + 7'(nd_crc);

    ahce_crc u_crc (
        .clk (clk),
        .ctl (crc_ctl),
        .crc (crc)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ahce_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = ahce_pkg::S_DIGIT;
            end
            ahce_pkg::S_DIGIT:
            begin
                if (adv && nd_reg[0] == 4'd1)
                    state_next = ahce_pkg::S_COMMA;
            end
            ahce_pkg::S_COMMA:
            begin
                if (adv)
                    state_next = (fcnt_reg == ahce_pkg::FIELD_LAST) ?
                                 ahce_pkg::S_CRC_LOAD : ahce_pkg::S_DIGIT;
            end
            ahce_pkg::S_CRC_LOAD:
            begin
                state_next = ahce_pkg::S_CRC_DIGIT;
            end
            ahce_pkg::S_CRC_DIGIT:
            begin
                if (adv && nd_reg[0] == 4'd1)
                    state_next = cr_en_reg ? ahce_pkg::S_CR : ahce_pkg::S_LF;
            end
            ahce_pkg::S_CR:
            begin
                if (adv)
                    state_next = ahce_pkg::S_LF;
            end
            ahce_pkg::S_LF:
            begin
                if (adv)
                    state_next = ahce_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ahce_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        emit           = 1'b0;
        emit_data      = '0;
        crc_ctl.init   = accept;
        crc_ctl.upd    = 1'b0;
        crc_ctl.data   = '0;
        case (state_reg)
            ahce_pkg::S_DIGIT:
            begin
                emit               = adv;
                emit_data.out_byte = ahce_pkg::hex_char(fld_reg[0][31:28]);
            end
            ahce_pkg::S_COMMA:
            begin
                emit               = adv;
                emit_data.out_byte = ahce_pkg::ASCII_COMMA;
            end
            ahce_pkg::S_CRC_DIGIT:
            begin
                emit               = adv;
                emit_data.out_byte = ahce_pkg::hex_char(fld_reg[0][31:28]);
            end
            ahce_pkg::S_CR:
            begin
                emit               = adv;
                emit_data.out_byte = ahce_pkg::ASCII_CR;
            end
            ahce_pkg::S_LF:
            begin
                emit               = adv;
                emit_data.out_byte = ahce_pkg::ASCII_LF;
                emit_data.last     = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        // length field (queue slot 0) is not part of the CRC
        if ((state_reg == ahce_pkg::S_DIGIT || state_reg == ahce_pkg::S_COMMA) &&
            fcnt_reg != 3'd0)
        begin
            crc_ctl.upd  = emit;
            crc_ctl.data = emit_data.out_byte;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ahce_pkg::S_IDLE;
            msg_type_reg  <= ahce_pkg::MSG_TYPE_RESET;
            seq_reg       <= '0;
            fcnt_reg      <= '0;
            cr_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= emit || (out_valid_reg && result_stall);
            if (cfg_we)
                msg_type_reg <= cfg_data;
            if (accept)
            begin
                seq_reg  <= seq_reg + 32'd1;
                fcnt_reg <= '0;
            end
            else if (state_reg == ahce_pkg::S_COMMA && emit)
                fcnt_reg <= fcnt_reg + 3'd1;
            if (state_reg == ahce_pkg::S_CRC_LOAD)
                cr_en_reg <= (line_len < ahce_pkg::CR_DROP_LEN);
        end
    end

    // datapath: field queue and output register
    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= emit_data;
        if (accept)
        begin
            plen_reg   <= plen;
            lendig_reg <= 2'(nd_plen);
            fld_reg[0] <= ahce_pkg::hex_align({26'h0, plen}, nd_plen);
            fld_reg[1] <= ahce_pkg::hex_align({24'h000000, msg_type_reg}, nd_type);
            fld_reg[2] <= ahce_pkg::hex_align(seq_reg, nd_seq);
            fld_reg[3] <= ahce_pkg::hex_align(item.count_x, nd_x);
            fld_reg[4] <= ahce_pkg::hex_align(item.count_y, nd_y);
            fld_reg[5] <= ahce_pkg::hex_align(item.count_z, nd_z);
            nd_reg[0]  <= nd_plen;
            nd_reg[1]  <= nd_type;
            nd_reg[2]  <= nd_seq;
            nd_reg[3]  <= nd_x;
            nd_reg[4]  <= nd_y;
            nd_reg[5]  <= nd_z;
        end
        else if (state_reg == ahce_pkg::S_CRC_LOAD)
        begin
            fld_reg[0] <= ahce_pkg::hex_align(crc, nd_crc);
            nd_reg[0]  <= nd_crc;
        end
        else if (emit && (state_reg == ahce_pkg::S_DIGIT ||
                          state_reg == ahce_pkg::S_CRC_DIGIT))
        begin
            fld_reg[0] <= fld_reg[0] << 4;
            nd_reg[0]  <= nd_reg[0] - 4'd1;
        end
        else if (emit && state_reg == ahce_pkg::S_COMMA)
        begin
            // advance the queue to the next field
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                fld_reg[i] <= fld_reg[i+1];
                nd_reg[i]  <= nd_reg[i+1];
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // CRC starts from its initial value on every new frame
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (crc == 32'h0000_0000))
        else $error("crc not initialized at frame start");

    // digit counter never runs out while digits are being issued
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ahce_pkg::S_DIGIT || state_reg == ahce_pkg::S_CRC_DIGIT)
        |-> (nd_reg[0] != 4'd0))
        else $error("digit counter underflow");

    // the marked final character is always the line feed
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.last) |-> (out_data_reg.out_byte == ahce_pkg::ASCII_LF))
        else $error("last set on a character other than line feed");

    // a new frame is only taken once the previous line has been fully issued
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == ahce_pkg::S_IDLE && !(emit && !emit_data.last)))
        else $error("frame accepted while a line is in progress");

endmodule

// ===== test/ascii_hex_crc_frame_encoder_core_test.sv =====
// Self-checking testbench for the ASCII hex CRC frame encoder core.
`timescale 1ns / 100ps

module ascii_hex_crc_frame_encoder_core_test;

    localparam int MAX_LINE = 51;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 75;

    // Predicts the character stream of each frame and checks it as it leaves.
    class frame_scoreboard;
        logic [7:0] msg_type = ahce_pkg::MSG_TYPE_RESET;
        logic [31:0] seq_count = '0;
        ahce_pkg::out_item_t expected_chars[$];
        int mismatches = 0;

        function void append_hex(ref logic [7:0] q[$], input logic [31:0] v, input bit comma);
            bit seen;
            logic [3:0] nib;
            seen = 1'b0;
            for (int k = 7; k >= 0; k--)
            begin
                nib = v[4*k +: 4];
                if (nib != 4'h0)
                    seen = 1'b1;
                if (seen)
                    q.push_back((nib < 4'd10) ? ahce_pkg::ASCII_ZERO + nib :
                                                ahce_pkg::ASCII_A + (nib - 4'd10));
            end
            if (!seen)
                q.push_back(ahce_pkg::ASCII_ZERO);
            if (comma)
                q.push_back(ahce_pkg::ASCII_COMMA);
        endfunction

        function void note_request(ahce_pkg::in_item_t v);
            logic [7:0] payload[$];
            logic [7:0] line[$];
            logic [31:0] crc;
            ahce_pkg::out_item_t c;
            append_hex(payload, {24'h0, msg_type}, 1'b1);
            append_hex(payload, seq_count, 1'b1);
            append_hex(payload, v.count_x, 1'b1);
            append_hex(payload, v.count_y, 1'b1);
            append_hex(payload, v.count_z, 1'b1);

            crc = ahce_pkg::CRC_INIT;
            foreach (payload[i])
            begin
                crc ^= {24'h0, payload[i]};
                repeat (8)
                    crc = crc[0] ? ((crc >> 1) ^ ahce_pkg::CRC_POLY) : (crc >> 1);
            end
            crc ^= ahce_pkg::CRC_XOROUT;

            append_hex(line, payload.size(), 1'b1);
            foreach (payload[i])
                line.push_back(payload[i]);
            append_hex(line, crc, 1'b0);
            // CR is dropped only when the full line would exceed the cap
            if (line.size() + 2 <= MAX_LINE)
                line.push_back(ahce_pkg::ASCII_CR);
            line.push_back(ahce_pkg::ASCII_LF);
            while (line.size() > MAX_LINE)
                void'(line.pop_back());

            foreach (line[i])
            begin
                c.out_byte = line[i];
                c.last = (i == line.size() - 1);
                expected_chars.push_back(c);
            end
            seq_count++;
        endfunction

        function void check_char(ahce_pkg::out_item_t got);
            ahce_pkg::out_item_t want;
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character: out_byte 0x%02h, last %0b", got.out_byte, got.last);
                mismatches++;
                return;
            end
            want = expected_chars.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    ahce_pkg::in_item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    ahce_pkg::out_item_t result;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_data = '0;

    bit steady = 1'b0;
    frame_scoreboard board = new;

    ascii_hex_crc_frame_encoder_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Output side: check each accepted character, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_char(result);
        result_stall <= !steady && ($urandom_range(99) < 11);
    end

    task automatic send_request(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z);
        ahce_pkg::in_item_t v;
        v.count_x = x;
        v.count_y = y;
        v.count_z = z;
        while (!steady && $urandom_range(99) < 11)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= v;
        do
            @(posedge clk);
        while (item_stall);
        board.note_request(v);
    endtask

    // Hold off new requests until every frame has fully left the block.
    task automatic drain;
        item_valid <= 1'b0;
        while (board.expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_type(input logic [7:0] t);
        cfg_we <= 1'b1;
        cfg_data <= t;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.msg_type = t;
    endtask

    function automatic logic [31:0] pick_count();
        logic [31:0] v;
        case ($urandom_range(7))
            0: v = '0;
            1: v = $urandom_range(15);
            2: v = $urandom_range(32'hFFF);
            3: v = -$urandom_range(4096, 1);
            4: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            5: v = $urandom >> $urandom_range(31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial
    begin
        logic [7:0] phase_types[6];
        phase_types = '{8'h5A, 8'h01, 8'hFF, 8'h00, 8'h10, 8'hA7};
        phase_types[0] = $urandom_range(255);
        phase_types[5] = $urandom_range(255);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the message type, extremes of the counts
        send_request(32'h0, 32'h0, 32'h0);
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(32'h1, 32'hF, 32'h10);
        send_request(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9);
        send_request(32'hFFFF_FFFE, 32'h0, 32'h7FFF_FFFF);
        send_request(32'hA, 32'h100, 32'hF000_0000);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001);
        drain();

        write_type(8'h00);
        send_request(32'h0, 32'h0, 32'h0);
        send_request(32'hFFFF_FFFF, 32'h1, 32'h8000_0000);
        send_request(32'h0000_00FF, 32'h00FF_FF00, 32'hFF00_0000);
        drain();

        // long lines: wide type and counts with a top nibble
        write_type(8'hFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h1000_0000);
        send_request(32'h0, 32'hFFFF_FFFF, 32'h0);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_type(phase_types[p]);
            steady = (p == 3);
            repeat (PHASE_ITEMS)
                send_request(pick_count(), pick_count(), pick_count());
            drain();
        end
        steady = 1'b0;

        repeat (60) @(posedge clk);
        if (board.mismatches == 0 && board.expected_chars.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
